// ===== rtl/imu_ocd_pkg.sv =====
// Shared types and constants for the inertial zero-offset calibrator.
package imu_ocd_pkg;

  // command codes carried by each input beat
  localparam logic [1:0] CMD_MEASURE = 2'd0;
  localparam logic [1:0] CMD_CAL     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam int CMD_W  = 2;
  localparam int CH_W   = 3;
  localparam int BYTE_W = 8;
  localparam int RAW_W  = 16;
  localparam int DB_W   = 8;
  localparam int VAL_W  = 14;

  // scaled sample, Q4 zero, calibration sum
  localparam int SAMP_W = 13;
  localparam int ZERO_W = 17;
  localparam int SUM_W  = 18;
  localparam int Q4_SH  = 4;

  localparam logic [CH_W-1:0] GYRO_CHANNELS = 3'd3;
  localparam int              GYRO_SH       = 4;
  localparam int              ACC_SH        = 3;

  localparam logic [DB_W-1:0] DB_RESET = 8'd3;

  typedef logic signed [VAL_W-1:0] val_t;

endpackage

// ===== rtl/imu_ocd_if.sv =====
// Valid/ready channel interfaces for the calibrator input and result beats.
interface imu_ocd_in_if
  import imu_ocd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CH_W-1:0]   channel;
  logic [BYTE_W-1:0] high_byte;
  logic [BYTE_W-1:0] low_byte;

  modport source (output valid, output cmd, output channel, output high_byte,
                  output low_byte, input ready);
  modport sink   (input valid, input cmd, input channel, input high_byte,
                  input low_byte, output ready);
endinterface

interface imu_ocd_out_if
  import imu_ocd_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_channel;
  val_t            value;
  logic            cal_done;
  logic            all_calibrated;

  modport source (output valid, output out_channel, output value, output cal_done,
                  output all_calibrated, input ready);
  modport sink   (input valid, input out_channel, input value, input cal_done,
                  input all_calibrated, output ready);
endinterface

// ===== rtl/imu_offset_calibrate_deadband.sv =====
// Inertial sample conditioner: zero-offset calibration, offset removal, gyro dead band.
//
// in_ch carries one beat per sample: command, channel and the raw big-endian byte pair.
// Every input beat produces exactly one beat on out_ch, in order.
// cfg_wr_en/cfg_wr_data load the gyro dead-band threshold; write it only while idle.
//
// An accepted beat passes through the compute stage registers, then the result register.
// Throughput: one beat per cycle while out_ch does not stall. Per-channel state (Q4 zero,
// running sum, count) sits in a register file with one read and one write port, read at
// accept; the compute stage does the read-modify-write and writes back as it hands its
// result on. The entry written in one cycle is forwarded to the beat read in that same
// cycle. Zero = sum*16/CAL_SAMPLES via a reciprocal multiply in the compute stage.
//
// Reset: dead band returns to 3, no channel is calibrated and all sums and counts are
// empty (per-channel valid flags, no clearing pass). A restart beat drops those flags.
// When out_ch stalls, the result register holds; the compute stage keeps one more beat
// and in_ch.ready falls only once both are full.
module imu_offset_calibrate_deadband
  import imu_ocd_pkg::*;
#(
  parameter int NUM_CHANNELS = 6,
  parameter int CAL_SAMPLES  = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DB_W-1:0]   cfg_wr_data,
  imu_ocd_in_if.sink        in_ch,
  imu_ocd_out_if.source     out_ch
);

  localparam int CH_AW   = $clog2(NUM_CHANNELS);
  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int MAG_W   = SUM_W - 1 + Q4_SH;
  localparam int DIV_SH  = MAG_W + $clog2(CAL_SAMPLES);
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int DIFF_W  = ZERO_W + 1;
  localparam logic [63:0] RECIP_L =
    ((64'd1 << DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

  typedef struct packed {
    logic signed [ZERO_W-1:0] zero;
    logic signed [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]         cnt;
  } ent_t;

  ent_t ent_mem_r [NUM_CHANNELS];
  ent_t rd_r;

  logic [DB_W-1:0]         db_r;
  logic                    s1_vld_r;
  logic [CMD_W-1:0]        s1_cmd_r;
  logic [CH_W-1:0]         s1_ch_r;
  logic [RAW_W-1:0]        s1_raw_r;
  logic [NUM_CHANNELS-1:0] cal_vld_r, cal_vld_nxt;
  logic [NUM_CHANNELS-1:0] cal_mask_r, cal_mask_nxt;
  logic                    fwd_vld_r;
  logic [CH_AW-1:0]        fwd_addr_r;
  ent_t                    fwd_ent_r;

  logic                    out_vld_r;
  logic [CH_W-1:0]         out_ch_r;
  val_t                    out_val_r;
  logic                    out_done_r;
  logic                    out_all_r;

  logic                    in_acc, s1_adv;
  logic [CH_AW-1:0]        in_addr, s1_addr;
  logic                    s1_inrng, s1_gyro, wr_en, done;
  logic signed [RAW_W-1:0] raw_s;
  logic signed [SAMP_W-1:0] samp;
  ent_t                    ent, wr_ent;
  logic signed [ZERO_W-1:0] cur_zero, new_zero;
  logic signed [SUM_W-1:0]  cur_sum, sum_new;
  logic [CNT_W-1:0]        cur_cnt, cnt_new;
  logic signed [DIFF_W-1:0] diff, diff_adj;
  logic signed [VAL_W:0]   v_wide, v_clamp, v_mag;
  val_t                    meas_val, res_val;
  logic [SUM_W-2:0]        sum_mag;
  logic [MAG_W-1:0]        div_mag;
  logic [PROD_W-1:0]       prod;
  logic [ZERO_W-1:0]       quot;

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_addr     = CH_AW'(in_ch.channel);
  assign s1_addr     = CH_AW'(s1_ch_r);

  always_comb begin
    s1_inrng = 32'(s1_ch_r) < 32'(NUM_CHANNELS);
    s1_gyro  = s1_ch_r < GYRO_CHANNELS;
    raw_s    = signed'(s1_raw_r);
    samp     = s1_gyro ? SAMP_W'(raw_s >>> GYRO_SH) : SAMP_W'(raw_s >>> ACC_SH);

    // newest copy of the entry: last write-back wins over the stale read
    ent      = (fwd_vld_r && fwd_addr_r == s1_addr) ? fwd_ent_r : rd_r;
    cur_zero = cal_mask_r[s1_addr] ? ent.zero : '0;
    cur_sum  = cal_vld_r[s1_addr] ? ent.sum : '0;
    cur_cnt  = cal_vld_r[s1_addr] ? ent.cnt : '0;

    // measure path: truncate (sample*16 - zero)/16 toward zero, clamp, dead band
    diff     = (DIFF_W'(samp) <<< Q4_SH) - DIFF_W'(cur_zero);
    diff_adj = diff[DIFF_W-1] ? diff + DIFF_W'(15) : diff;
    v_wide   = (VAL_W+1)'(diff_adj >>> Q4_SH);
    if (v_wide > (VAL_W+1)'(8191)) begin
      v_clamp = (VAL_W+1)'(8191);
    end else if (v_wide < -(VAL_W+1)'(8192)) begin
      v_clamp = -(VAL_W+1)'(8192);
    end else begin
      v_clamp = v_wide;
    end
    v_mag    = v_clamp[VAL_W] ? -v_clamp : v_clamp;
    meas_val = (s1_gyro && unsigned'(v_mag) <= (VAL_W+1)'(db_r)) ? '0
                                                                    : VAL_W'(v_clamp);

    // calibration path: accumulate, then zero = trunc(sum*16/CAL_SAMPLES)
    sum_new  = cur_sum + SUM_W'(samp);
    cnt_new  = cur_cnt + CNT_W'(1);
    done     = cnt_new >= CNT_W'(CAL_SAMPLES);
    sum_mag  = sum_new[SUM_W-1] ? (SUM_W-1)'(-sum_new) : (SUM_W-1)'(sum_new);
    div_mag  = {sum_mag, {Q4_SH{1'b0}}};
    prod     = PROD_W'(div_mag) * PROD_W'(RECIP);
    quot     = prod[DIV_SH +: ZERO_W];
    new_zero = sum_new[SUM_W-1] ? -signed'(quot) : signed'(quot);

    wr_en  = 1'b0;
    done   = done && s1_inrng && (s1_cmd_r == CMD_CAL);
    wr_ent = done ? ent_t'{zero: new_zero, sum: '0, cnt: '0}
                  : ent_t'{zero: cur_zero, sum: sum_new, cnt: cnt_new};
    res_val      = '0;
    cal_vld_nxt  = cal_vld_r;
    cal_mask_nxt = cal_mask_r;
    case (s1_cmd_r)
      CMD_MEASURE: begin
        if (s1_inrng) begin
          res_val = meas_val;
        end
      end
      CMD_CAL: begin
        if (s1_inrng) begin
          res_val              = VAL_W'(samp);
          wr_en                = s1_adv;
          cal_vld_nxt[s1_addr] = 1'b1;
          if (done) begin
            cal_mask_nxt[s1_addr] = 1'b1;
          end
        end
      end
      CMD_RESTART: begin
        cal_vld_nxt = '0;
      end
      default: begin
        res_val = '0;
      end
    endcase
  end

  // per-channel register file with a registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem_r[s1_addr] <= wr_ent;
    end
    if (in_acc) begin
      rd_r <= ent_mem_r[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_r       <= DB_RESET;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      cal_vld_r  <= '0;
      cal_mask_r <= '0;
      fwd_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        db_r <= cfg_wr_data;
      end
      if (in_ch.ready) begin
        s1_vld_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_vld_r  <= 1'b1;
        cal_vld_r  <= cal_vld_nxt;
        cal_mask_r <= cal_mask_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (wr_en) begin
        fwd_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_ch.cmd;
      s1_ch_r  <= in_ch.channel;
      s1_raw_r <= {in_ch.high_byte, in_ch.low_byte};
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr;
      fwd_ent_r  <= wr_ent;
    end
    if (s1_adv) begin
      out_ch_r   <= s1_ch_r;
      out_val_r  <= res_val;
      out_done_r <= done;
      out_all_r  <= &cal_mask_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.out_channel    = out_ch_r;
  assign out_ch.value          = out_val_r;
  assign out_ch.cal_done       = out_done_r;
  assign out_ch.all_calibrated = out_all_r;

endmodule
